// File: rtl/rrt_pkg.sv
// Shared types and constants for the retransmit request table.
`timescale 1ns / 1ps

package rrt_pkg;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] RETRY_GAP_RST = 32'd1000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_ARRIVE = 2'd2,
    CMD_CLEAN  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_MATCHED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_CLEANED   = 3'd4,
    STAT_DUE       = 3'd5,
    STAT_NONE_DUE  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] source_id;
    logic [31:0] source_seq;
    logic [31:0] own_seq;
  } entry_t;

endpackage

// File: rtl/rrt_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface rrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now_time;
  logic [31:0] stamp;
  logic [31:0] source_id;
  logic [31:0] source_seq;
  logic [31:0] own_seq;

  modport source (output valid, cmd, now_time, stamp, source_id, source_seq, own_seq,
                  input ready);
  modport sink   (input valid, cmd, now_time, stamp, source_id, source_seq, own_seq,
                  output ready);
endinterface

interface rrt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_stamp;
  logic [31:0] out_source_id;
  logic [31:0] out_source_seq;
  logic [31:0] out_own_seq;
  logic        last;

  modport source (output valid, status, out_stamp, out_source_id, out_source_seq,
                  out_own_seq, last, input ready);
  modport sink   (input valid, status, out_stamp, out_source_id, out_source_seq,
                  out_own_seq, last, output ready);
endinterface

// File: rtl/rrt_ram.sv
// Simple dual-port slot memory with registered read.
`timescale 1ns / 1ps

module rrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rrt_ctrl.sv
// Command sequencer: slot scan, shared compare, valid bits and result register.
`timescale 1ns / 1ps

module rrt_ctrl import rrt_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  rrt_req_if.sink          req,
  rrt_res_if.source        res,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  // slot data memory
  output logic             d_re,
  output logic [IDX_W-1:0] d_raddr,
  input  entry_t           d_rdata,
  output logic             d_we,
  output logic [IDX_W-1:0] d_waddr,
  output entry_t           d_wdata,
  // last-check time memory
  output logic             c_we,
  output logic [IDX_W-1:0] c_waddr,
  output logic [31:0]      c_wdata,
  input  logic [31:0]      c_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [31:0]            line_r, line_nxt;
  entry_t                 req_r, req_nxt;
  logic [31:0]            gap_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   rd_done_r, rd_done_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  entry_t                 pend_r, pend_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  status_t                fin_r, fin_nxt;

  logic                   out_vld_r, out_vld_nxt;
  status_t                out_status_r, out_status_nxt;
  entry_t                 out_ent_r, out_ent_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic                   hit;
  logic                   stall;
  logic [32:0]            diff;
  logic                   push;
  status_t                push_status;
  entry_t                 push_ent;
  logic                   push_last;

  assign out_free = !out_vld_r || res.ready;
  assign diff     = {1'b0, req.now_time} - {1'b0, gap_r};

  // shared compare on the slot whose data has just come out of memory
  always_comb begin
    hit = 1'b0;
    if (cmp_vld_r && valid_r[cmp_idx_r]) begin
      case (cmd_r)
        CMD_POLL:   hit = (c_rdata <= line_r) && (cnt_r != CNT_MAX);
        CMD_ARRIVE: hit = !found_r && (d_rdata.own_seq == req_r.own_seq) &&
                          (d_rdata.stamp == req_r.stamp);
        CMD_CLEAN:  hit = (d_rdata.stamp == req_r.stamp);
        default:    hit = 1'b0;
      endcase
    end
  end

  assign stall = hit && (cmd_r == CMD_POLL) && pend_vld_r && !out_free;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    now_nxt      = now_r;
    line_nxt     = line_r;
    req_nxt      = req_r;
    valid_nxt    = valid_r;
    occ_nxt      = occ_r;
    rd_idx_nxt   = rd_idx_r;
    rd_done_nxt  = rd_done_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    fin_nxt      = fin_r;
    d_re         = 1'b0;
    d_raddr      = rd_idx_r;
    d_we         = 1'b0;
    d_waddr      = rd_idx_r;
    d_wdata      = req_r;
    c_we         = 1'b0;
    c_waddr      = cmp_idx_r;
    c_wdata      = now_r;
    push         = 1'b0;
    push_status  = fin_r;
    push_ent     = '0;
    push_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          cmd_nxt      = cmd_t'(req.cmd);
          now_nxt      = req.now_time;
          line_nxt     = diff[32] ? 32'd0 : diff[31:0];
          req_nxt      = '{stamp: req.stamp, source_id: req.source_id,
                           source_seq: req.source_seq, own_seq: req.own_seq};
          rd_idx_nxt   = '0;
          rd_done_nxt  = 1'b0;
          cmp_vld_nxt  = 1'b0;
          found_nxt    = 1'b0;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          if ((cmd_t'(req.cmd) == CMD_ADD) && (occ_r == FULL_OCC)) begin
            fin_nxt   = STAT_FULL;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cmd_r == CMD_ADD) begin
          // walk the valid bits for the lowest free slot
          if (!valid_r[rd_idx_r]) begin
            d_we                 = 1'b1;
            c_we                 = 1'b1;
            c_waddr              = rd_idx_r;
            c_wdata              = 32'd0;
            valid_nxt[rd_idx_r]  = 1'b1;
            occ_nxt              = occ_r + 1'b1;
            fin_nxt              = STAT_ADDED;
            state_nxt            = S_FINISH;
          end else if (rd_idx_r == LAST_IDX) begin
            fin_nxt   = STAT_FULL;
            state_nxt = S_FINISH;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end else if (!stall) begin
          if (hit) begin
            case (cmd_r)
              CMD_POLL: begin
                c_we         = 1'b1;
                cnt_nxt      = cnt_r + 1'b1;
                pend_vld_nxt = 1'b1;
                pend_nxt     = d_rdata;
                // older due entry goes out now; the newest is held back for last
                if (pend_vld_r) begin
                  push        = 1'b1;
                  push_status = STAT_DUE;
                  push_ent    = pend_r;
                  push_last   = 1'b0;
                end
              end
              CMD_ARRIVE: begin
                valid_nxt[cmp_idx_r] = 1'b0;
                occ_nxt              = occ_r - 1'b1;
                found_nxt            = 1'b1;
              end
              CMD_CLEAN: begin
                valid_nxt[cmp_idx_r] = 1'b0;
                occ_nxt              = occ_r - 1'b1;
              end
              default: ;
            endcase
          end
          d_re        = !rd_done_r;
          cmp_vld_nxt = !rd_done_r;
          cmp_idx_nxt = rd_idx_r;
          if (!rd_done_r) begin
            if (rd_idx_r == LAST_IDX) begin
              rd_done_nxt = 1'b1;
            end else begin
              rd_idx_nxt = rd_idx_r + 1'b1;
            end
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          case (cmd_r)
            CMD_POLL: begin
              if (pend_vld_r) begin
                push_status = STAT_DUE;
                push_ent    = pend_r;
              end else begin
                push_status = STAT_NONE_DUE;
              end
            end
            CMD_ARRIVE: push_status = found_r ? STAT_MATCHED : STAT_NOT_FOUND;
            CMD_CLEAN:  push_status = STAT_CLEANED;
            default:    push_status = fin_r;
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_vld_nxt    = out_vld_r && !res.ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_last_nxt   = out_last_r;
    if (push) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = push_status;
      out_ent_nxt    = push_ent;
      out_last_nxt   = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      gap_r      <= RETRY_GAP_RST;
      valid_r    <= '0;
      occ_r      <= '0;
      out_vld_r  <= 1'b0;
      rd_done_r  <= 1'b0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      valid_r    <= valid_nxt;
      occ_r      <= occ_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_done_r  <= rd_done_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      found_r    <= found_nxt;
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    now_r        <= now_nxt;
    line_r       <= line_nxt;
    req_r        <= req_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pend_r       <= pend_nxt;
    fin_r        <= fin_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign req.ready          = (state_r == S_IDLE);
  assign res.valid          = out_vld_r;
  assign res.status         = out_status_r;
  assign res.out_stamp      = out_ent_r.stamp;
  assign res.out_source_id  = out_ent_r.source_id;
  assign res.out_source_seq = out_ent_r.source_seq;
  assign res.out_own_seq    = out_ent_r.own_seq;
  assign res.last           = out_last_r;

endmodule

// File: rtl/retransmit_request_table_top.sv
// Top level of the retransmit request table.
`timescale 1ns / 1ps
//
// Holds up to TABLE_DEPTH pending retransmit requests. One request on in_req
// carries a command: add, poll, arrive or clean. Results leave on out_res with
// valid/ready; last marks the final result of a request. Poll gives one result
// per due entry (at most 32) or a single none-due result; every other command
// gives exactly one result. cfg_we/cfg_wdata load the retry gap; the user
// must write it only while idle, and the block itself does not enforce this.
// Sequence: add moves from idle to the scan state, which walks the valid bits
// for the lowest free slot, then to the finish state, which registers its
// result; when the table is full it goes straight to finish. Poll, arrive and
// clean walk every slot through one memory read port and one shared
// comparator, one slot a cycle unless a poll stalls; the final result is
// registered in the finish state. in_req.ready is high only between requests
// and returns as the final result is registered. A result waits in the output
// register without holding back the next request; if the receiver stalls
// while a poll has a further due entry, the scan pauses until it drains, and
// a final result waits until the output register is free.
//
// Reset clears all valid bits, the occupancy count and the output register,
// and loads the retry gap with 1000. Slot memories are not cleared.

module retransmit_request_table_top import rrt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rrt_req_if.sink     in_req,
  rrt_res_if.source   out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic             d_re;
  logic [IDX_W-1:0] d_raddr;
  entry_t           d_rdata;
  logic             d_we;
  logic [IDX_W-1:0] d_waddr;
  entry_t           d_wdata;
  logic             c_we;
  logic [IDX_W-1:0] c_waddr;
  logic [31:0]      c_wdata;
  logic [31:0]      c_rdata;

  rrt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .res       (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .d_re      (d_re),
    .d_raddr   (d_raddr),
    .d_rdata   (d_rdata),
    .d_we      (d_we),
    .d_waddr   (d_waddr),
    .d_wdata   (d_wdata),
    .c_we      (c_we),
    .c_waddr   (c_waddr),
    .c_wdata   (c_wdata),
    .c_rdata   (c_rdata)
  );

  rrt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // last-check times share the read address with the slot data
  rrt_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_check_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (c_rdata)
  );

endmodule
